// File: rtl/u2u8_pkg.sv
// shared types and constants for the utf-16 to utf-8 encoder
package u2u8_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_BAD_PAIR   = 2'd2
  } status_t;

  // one run of results caused by one input word; count 0 means status only
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
    status_t         status;
    logic            strm_end;
  } run_t;

  localparam logic [21:0] LeadTag  = 22'h36;
  localparam logic [21:0] TrailTag = 22'h37;
  localparam logic [31:0] SuppBase = 32'h0001_0000;

endpackage

// File: rtl/u2u8_front.sv
// front end: config register, surrogate pairing and utf-8 byte formation
module u2u8_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_valid,
  input  logic [31:0]       in_code_unit,
  input  logic              in_last_unit,
  input  logic              q_ready,
  output logic              in_ready,
  output logic              q_push,
  output u2u8_pkg::run_t    q_run
);

  logic       wide_r;
  logic [9:0] held_r, held_nxt;
  logic       lead_r, lead_nxt;
  logic       drop_r, drop_nxt;

  logic [31:0]     unit;
  logic [31:0]     cp;
  logic            is_trail;
  logic            is_lead;
  logic            emit;
  logic [2:0]      n;
  logic [3:0][7:0] b;
  u2u8_pkg::run_t  run;
  logic            acc;

  assign in_ready = q_ready;
  assign acc      = in_valid && in_ready;

  assign unit     = wide_r ? in_code_unit : {16'h0000, in_code_unit[15:0]};
  assign is_trail = (unit[31:10] == u2u8_pkg::TrailTag);
  assign is_lead  = !wide_r && (unit[31:10] == u2u8_pkg::LeadTag);

  // code point to encode
  always_comb begin
    if (lead_r) begin
      cp = u2u8_pkg::SuppBase + {12'h000, held_r, unit[9:0]};
    end else begin
      cp = unit;
    end
  end

  // utf-8 byte formation
  always_comb begin
    n = 3'd0;
    b = '0;
    if (cp <= 32'h7f) begin
      n    = 3'd1;
      b[0] = cp[7:0];
    end else if (cp <= 32'h7ff) begin
      n    = 3'd2;
      b[0] = {3'b110, cp[10:6]};
      b[1] = {2'b10, cp[5:0]};
    end else if (cp <= 32'hd7ff || (cp > 32'hdfff && cp <= 32'hffff)) begin
      n    = 3'd3;
      b[0] = {4'b1110, cp[15:12]};
      b[1] = {2'b10, cp[11:6]};
      b[2] = {2'b10, cp[5:0]};
    end else if (cp > 32'hffff && cp <= 32'h10ffff) begin
      n    = 3'd4;
      b[0] = {5'b11110, cp[20:18]};
      b[1] = {2'b10, cp[17:12]};
      b[2] = {2'b10, cp[11:6]};
      b[3] = {2'b10, cp[5:0]};
    end
  end

  // classification and state update
  always_comb begin
    held_nxt     = held_r;
    lead_nxt     = lead_r;
    drop_nxt     = drop_r;
    emit         = 1'b0;
    run          = '0;
    run.status   = u2u8_pkg::ST_OK;
    run.strm_end = in_last_unit;
    if (drop_r) begin
      emit       = in_last_unit;
      run.status = u2u8_pkg::ST_BAD_PAIR;
    end else if (lead_r && !is_trail) begin
      emit       = 1'b1;
      run.status = u2u8_pkg::ST_BAD_PAIR;
      lead_nxt   = 1'b0;
      held_nxt   = '0;
      drop_nxt   = !in_last_unit;
    end else if (!lead_r && is_lead) begin
      if (in_last_unit) begin
        emit       = 1'b1;
        run.status = u2u8_pkg::ST_INCOMPLETE;
      end else begin
        lead_nxt = 1'b1;
        held_nxt = unit[9:0];
      end
    end else begin
      lead_nxt  = 1'b0;
      held_nxt  = '0;
      run.bytes = b;
      run.count = n;
      emit      = (n != 3'd0) || in_last_unit;
    end
    if (in_last_unit) begin
      held_nxt = '0;
      lead_nxt = 1'b0;
      drop_nxt = 1'b0;
    end
  end

  assign q_push = acc && emit;
  assign q_run  = run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r <= 1'b0;
      held_r <= '0;
      lead_r <= 1'b0;
      drop_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        wide_r <= cfg_wr_data;
      end
      if (acc) begin
        held_r <= held_nxt;
        lead_r <= lead_nxt;
        drop_r <= drop_nxt;
      end
    end
  end

endmodule

// File: rtl/u2u8_queue.sv
// small queue of byte runs between the front and back ends
module u2u8_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  u2u8_pkg::run_t push_run,
  output logic           ready,
  input  logic           pop,
  output logic           q_valid,
  output u2u8_pkg::run_t q_run
);

  u2u8_pkg::run_t mem [u2u8_pkg::QDepth];

  logic [u2u8_pkg::QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [u2u8_pkg::QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [u2u8_pkg::QCntW-1:0] cnt_r, cnt_nxt;
  logic                       do_push;
  logic                       do_pop;

  assign ready   = (cnt_r != u2u8_pkg::QCntW'(u2u8_pkg::QDepth));
  assign q_valid = (cnt_r != '0);
  assign q_run   = mem[rd_ptr_r];
  assign do_push = push && ready;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: rtl/u2u8_back.sv
// back end: serializes byte runs into output words through an output register
module u2u8_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  u2u8_pkg::run_t q_run,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_byte_valid,
  output logic           out_run_end,
  output logic [1:0]     out_status,
  output logic           out_stream_end
);

  u2u8_pkg::run_t cur_r;
  logic           cur_valid_r, cur_valid_nxt;
  logic [1:0]     idx_r, idx_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     byte_r;
  logic           bval_r;
  logic           rend_r;
  logic [1:0]     stat_r;
  logic           send_r;

  logic       out_free;
  logic       take;
  logic       fin;
  logic [1:0] cnt_m1;
  logic [1:0] last_idx;

  assign out_free = !out_valid_r || out_ready;
  assign cnt_m1   = cur_r.count[1:0] - 2'd1;
  assign last_idx = (cur_r.count == 3'd0) ? 2'd0 : cnt_m1;
  assign take     = cur_valid_r && out_free;
  assign fin      = take && (idx_r == last_idx);
  assign q_pop    = q_valid && (!cur_valid_r || fin);

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      idx_nxt       = 2'd0;
    end else if (fin) begin
      cur_valid_nxt = 1'b0;
      idx_nxt       = 2'd0;
    end else if (take) begin
      idx_nxt = idx_r + 2'd1;
    end
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_run;
    end
    if (take) begin
      bval_r <= (cur_r.count != 3'd0);
      byte_r <= (cur_r.count == 3'd0) ? 8'h00 : cur_r.bytes[idx_r];
      rend_r <= (idx_r == last_idx);
      stat_r <= cur_r.status;
      send_r <= cur_r.strm_end && (idx_r == last_idx);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = byte_r;
  assign out_byte_valid = bval_r;
  assign out_run_end    = rend_r;
  assign out_status     = stat_r;
  assign out_stream_end = send_r;

endmodule

// File: rtl/utf16_to_utf8_encoder_top.sv
// top level of the utf-16 / utf-32 to utf-8 encoder
//
// input channel: in_valid/in_ready carry one code unit word (in_code_unit,
// in_last_unit) per cycle while in_ready is high; a high surrogate is held
// and paired with the next word. output channel: out_valid/out_ready carry
// one utf-8 byte word per cycle while out_ready is high, with byte_valid,
// run_end, status and stream_end marks. cfg_wr_en/cfg_wr_data write the
// wide-units mode bit; the user must write it only while idle, which the
// block does not enforce. each word passes the run queue and current-run
// register before its bytes reach the output register. a word that forms n
// bytes occupies the output for n words, and a four-entry run queue lets
// input continue while longer runs drain. reset: synchronous active-low rst_n
// clears the mode bit, the held surrogate, the drop state, the queue and the
// output register. when the receiver stalls, the output register holds its
// word, the queue fills, and in_ready drops once four runs are waiting.
module utf16_to_utf8_encoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_code_unit,
  input  logic        in_last_unit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_run_end,
  output logic [1:0]  out_status,
  output logic        out_stream_end
);

  logic           q_ready;
  logic           q_push;
  u2u8_pkg::run_t push_run;
  logic           q_pop;
  logic           q_valid;
  u2u8_pkg::run_t head_run;

  u2u8_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_code_unit (in_code_unit),
    .in_last_unit (in_last_unit),
    .q_ready      (q_ready),
    .in_ready     (in_ready),
    .q_push       (q_push),
    .q_run        (push_run)
  );

  u2u8_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_run (push_run),
    .ready    (q_ready),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_run    (head_run)
  );

  u2u8_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_run          (head_run),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_run_end    (out_run_end),
    .out_status     (out_status),
    .out_stream_end (out_stream_end)
  );

endmodule

// File: tb/utf16_to_utf8_encoder_top_tb.sv
// self-checking testbench for the utf-16 / utf-32 to utf-8 encoder
module utf16_to_utf8_encoder_top_tb;

  localparam int QUIET_CYCLES = 8;
  localparam int RANDOM_UNITS = 320;

  typedef enum logic [1:0] {
    JOB_UNIT,
    JOB_MODE,
    JOB_DRAIN
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [31:0] code;
    logic        last;
    logic        mode;
  } job_t;

  typedef struct packed {
    logic [7:0]        data;
    logic              valid;
    logic              run_end;
    u2u8_pkg::status_t status;
    logic              stream_end;
  } utf8_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_code_unit = 32'h0;
  logic        in_last_unit = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        out_run_end;
  logic [1:0]  out_status;
  logic        out_stream_end;

  job_t       unit_jobs[$];
  utf8_word_t utf8_expected[$];
  int         units_queued = 0;
  int         fail_count = 0;

  logic       wide_mode = 1'b0;
  logic [9:0] lead_bits = 10'h0;
  logic       lead_pending = 1'b0;
  logic       drop_rest = 1'b0;

  int         burst_left = 0;
  int         gap_left = 0;
  int         quiet_count = 0;
  logic [15:0] ready_mask = 16'hffff;
  logic [3:0]  stall_phase = 4'h0;

  utf16_to_utf8_encoder_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_code_unit   (in_code_unit),
    .in_last_unit   (in_last_unit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_run_end    (out_run_end),
    .out_status     (out_status),
    .out_stream_end (out_stream_end)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic add_unit(input logic [31:0] code, input logic fin);
    job_t j;
    j.kind = JOB_UNIT;
    j.code = code;
    j.last = fin;
    j.mode = 1'b0;
    unit_jobs.push_back(j);
    units_queued++;
  endtask

  task automatic add_mode(input logic m);
    job_t j;
    j.kind = JOB_MODE;
    j.code = 32'h0;
    j.last = 1'b0;
    j.mode = m;
    unit_jobs.push_back(j);
  endtask

  task automatic add_drain();
    job_t j;
    j.kind = JOB_DRAIN;
    j.code = 32'h0;
    j.last = 1'b0;
    j.mode = 1'b0;
    unit_jobs.push_back(j);
  endtask

  task automatic add_utf8_word(input logic [7:0] data, input logic valid, input logic re,
                               input u2u8_pkg::status_t st, input logic se);
    utf8_word_t w;
    w.data = data;
    w.valid = valid;
    w.run_end = re;
    w.status = st;
    w.stream_end = se;
    utf8_expected.push_back(w);
  endtask

  // utf-8 bytes produced by one accepted code unit word
  task automatic encode_unit(input logic [31:0] unit, input logic fin);
    logic [31:0]     cp;
    logic [3:0][7:0] seq;
    int              n;
    logic            handled;
    cp = wide_mode ? unit : {16'h0, unit[15:0]};
    n = 0;
    handled = 1'b0;
    seq = '0;
    if (drop_rest) begin
      handled = 1'b1;
      if (fin) begin
        drop_rest = 1'b0;
        lead_pending = 1'b0;
        lead_bits = 10'h0;
        add_utf8_word(8'h00, 1'b0, 1'b1, u2u8_pkg::ST_BAD_PAIR, 1'b1);
      end
    end else if (lead_pending) begin
      lead_pending = 1'b0;
      if ((cp & 32'hffff_fc00) != 32'h0000_dc00) begin
        handled = 1'b1;
        lead_bits = 10'h0;
        drop_rest = !fin;
        add_utf8_word(8'h00, 1'b0, 1'b1, u2u8_pkg::ST_BAD_PAIR, fin);
      end else begin
        cp = 32'h0001_0000 + {12'h0, lead_bits, 10'h0} + {22'h0, cp[9:0]};
        lead_bits = 10'h0;
      end
    end else if (!wide_mode && (cp & 32'hffff_fc00) == 32'h0000_d800) begin
      handled = 1'b1;
      if (fin) begin
        add_utf8_word(8'h00, 1'b0, 1'b1, u2u8_pkg::ST_INCOMPLETE, 1'b1);
      end else begin
        lead_bits = cp[9:0];
        lead_pending = 1'b1;
      end
    end
    if (!handled) begin
      if (cp <= 32'h7f) begin
        seq[0] = cp[7:0];
        n = 1;
      end else if (cp <= 32'h7ff) begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
        n = 2;
      end else if (cp <= 32'hd7ff || (cp > 32'hdfff && cp <= 32'hffff)) begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
        n = 3;
      end else if (cp > 32'hffff && cp <= 32'h10ffff) begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
        n = 4;
      end
      if (fin) begin
        lead_pending = 1'b0;
        lead_bits = 10'h0;
        drop_rest = 1'b0;
      end
      if (n == 0) begin
        if (fin) add_utf8_word(8'h00, 1'b0, 1'b1, u2u8_pkg::ST_OK, 1'b1);
      end else begin
        for (int k = 0; k < n; k++)
          add_utf8_word(seq[k], 1'b1, k == n - 1, u2u8_pkg::ST_OK, (k == n - 1) && fin);
      end
    end
  endtask

  // one code point, surrogate pair or piece of noise
  task automatic add_token(input logic mode, input logic fin);
    int          cls;
    logic [31:0] cp;
    logic [31:0] v;
    logic [31:0] g;
    logic [31:0] hi_a;
    logic [31:0] hi_b;
    cls = $urandom_range(0, 19);
    g = $urandom;
    hi_a = ($urandom_range(0, 3) == 0) ? {g[31:16], 16'h0} : 32'h0;
    hi_b = ($urandom_range(0, 3) == 0) ? {g[15:0], 16'h0} : 32'h0;
    if (cls <= 16) begin
      if (cls <= 4) cp = $urandom_range(0, 127);
      else if (cls <= 8) cp = $urandom_range(128, 2047);
      else if (cls <= 12) cp = $urandom_range(0, 1) ? $urandom_range(2048, 32'hd7ff)
                                                  : $urandom_range(32'he000, 32'hffff);
      else cp = $urandom_range(32'h1_0000, 32'h10_ffff);
      if (mode) begin
        add_unit(cp, fin);
      end else if (cp < 32'h1_0000) begin
        add_unit(hi_a | cp, fin);
      end else begin
        v = cp - 32'h1_0000;
        add_unit(hi_a | 32'hd800 | v[19:10], 1'b0);
        add_unit(hi_b | 32'hdc00 | v[9:0], fin);
      end
    end else begin
      case ($urandom_range(0, 3))
        0: add_unit($urandom, fin);
        1: add_unit((mode ? 32'h0 : hi_a) | 32'hdc00 | $urandom_range(0, 1023), fin);
        2: begin
          if (mode) begin
            add_unit($urandom_range(32'h0011_0000, 32'hffff_ffff), fin);
          end else begin
            add_unit(hi_a | 32'hd800 | $urandom_range(0, 1023), 1'b0);
            add_unit(hi_b | $urandom_range(0, 32'hd7ff), fin);
          end
        end
        default: add_unit((mode ? 32'h0 : hi_a) | $urandom_range(32'hd800, 32'hdbff), fin);
      endcase
    end
  endtask

  // driver: bursts of words with gaps, mode writes and drains only once idle
  always @(posedge clk) begin : drive_units
    logic nxt_valid;
    logic nxt_cfg;
    job_t j;
    nxt_valid = in_valid;
    nxt_cfg = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        encode_unit(in_code_unit, in_last_unit);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (unit_jobs.size() > 0) begin
          if (unit_jobs[0].kind == JOB_UNIT) begin
            j = unit_jobs.pop_front();
            in_code_unit <= j.code;
            in_last_unit <= j.last;
            nxt_valid = 1'b1;
            if (burst_left > 0) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(0, 15);
              gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
          end else if (utf8_expected.size() != 0 || in_valid) begin
            quiet_count = 0;
          end else if (quiet_count < QUIET_CYCLES) begin
            quiet_count++;
          end else begin
            quiet_count = 0;
            j = unit_jobs.pop_front();
            if (j.kind == JOB_MODE) begin
              nxt_cfg = 1'b1;
              cfg_wr_data <= j.mode;
              wide_mode = j.mode;
            end
          end
        end
      end
    end
    in_valid <= nxt_valid;
    cfg_wr_en <= nxt_cfg;
  end

  // monitor: checks each accepted byte word, receiver stalls follow a random 16-bit ready mask
  always @(posedge clk) begin : watch_bytes
    utf8_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (utf8_expected.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual byte=%h bv=%b re=%b st=%0d se=%b",
                 $time, out_byte, out_byte_valid, out_run_end, out_status, out_stream_end);
        fail_count++;
      end else begin
        want = utf8_expected.pop_front();
        if (want.data != out_byte || want.valid != out_byte_valid ||
            want.run_end != out_run_end || want.status != out_status ||
            want.stream_end != out_stream_end) begin
          $display("%0t: mismatch, expected %h/%b/%b/%0d/%b, actual %h/%b/%b/%0d/%b",
                   $time, want.data, want.valid, want.run_end, want.status, want.stream_end,
                   out_byte, out_byte_valid, out_run_end, out_status, out_stream_end);
          fail_count++;
        end
      end
    end
    if (stall_phase == 4'h0) begin
      case ($urandom_range(0, 3))
        0: ready_mask = 16'hffff;
        1: ready_mask = $urandom;
        2: ready_mask = $urandom & $urandom;
        default: ready_mask = $urandom | $urandom;
      endcase
    end
    out_ready <= ready_mask[stall_phase];
    stall_phase = stall_phase + 4'h1;
  end

  initial begin
    int  n;
    int  next_switch;
    logic phase_mode;

    add_mode(1'b0);
    add_unit(32'h0000_0000, 1'b0);
    add_unit(32'h0000_007f, 1'b0);
    add_unit(32'h0000_0080, 1'b0);
    add_unit(32'h0000_07ff, 1'b0);
    add_unit(32'h0000_d7ff, 1'b0);
    add_unit(32'h0000_e000, 1'b0);
    add_unit(32'h0000_ffff, 1'b1);
    // lowest and highest supplementary pairs
    add_unit(32'h0000_d800, 1'b0);
    add_unit(32'h0000_dc00, 1'b0);
    add_unit(32'h0000_dbff, 1'b0);
    add_unit(32'h0000_dfff, 1'b1);
    // lone low surrogate, upper half ignored
    add_unit(32'h0000_dc00, 1'b0);
    add_unit(32'hffff_0041, 1'b1);
    // broken pair then dropped words
    add_unit(32'h0000_d800, 1'b0);
    add_unit(32'h0000_0041, 1'b0);
    add_unit(32'h0000_0042, 1'b0);
    add_unit(32'h0000_0043, 1'b1);
    // broken pair on the last word
    add_unit(32'h0000_d801, 1'b0);
    add_unit(32'h0000_0041, 1'b1);
    // trailing lead
    add_unit(32'h0000_d802, 1'b1);
    // last word with no bytes to emit
    add_unit(32'h0000_dfff, 1'b1);
    // lead held across a switch to wide mode
    add_unit(32'h0000_d83d, 1'b0);
    add_mode(1'b1);
    add_unit(32'h0000_de00, 1'b0);
    add_unit(32'h0010_ffff, 1'b0);
    add_unit(32'h0011_0000, 1'b0);
    add_unit(32'h0000_d800, 1'b0);
    add_unit(32'hffff_ffff, 1'b1);
    add_drain();
    add_mode(1'b0);

    phase_mode = 1'b0;
    next_switch = units_queued + $urandom_range(40, 80);
    while (units_queued < RANDOM_UNITS) begin
      if (units_queued >= next_switch) begin
        next_switch = units_queued + $urandom_range(40, 80);
        phase_mode = ~phase_mode;
        add_mode(phase_mode);
      end
      if ($urandom_range(0, 15) == 0) add_drain();
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++)
        add_token(phase_mode, k == n - 1);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (unit_jobs.size() != 0 || in_valid || utf8_expected.size() != 0)
      @(negedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    if (utf8_expected.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, utf8_expected.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("utf16_to_utf8_encoder_top_tb OK");
    end else begin
      $display("utf16_to_utf8_encoder_top_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("%0t: timeout", $time);
    $display("utf16_to_utf8_encoder_top_tb NOT OK");
    $finish;
  end

endmodule

// File: files.f
rtl/u2u8_pkg.sv
rtl/u2u8_front.sv
rtl/u2u8_queue.sv
rtl/u2u8_back.sv
rtl/utf16_to_utf8_encoder_top.sv
tb/utf16_to_utf8_encoder_top_tb.sv
